FILE: design/dpw_pkg.sv
// dpw_pkg: widths, types, register indexes and reset values for the
// depth pixel to world point pipeline. No dependencies.
`timescale 1ns / 1ps

package dpw_pkg;

   // Pixel grid
   localparam int COORD_BITS     = 11;
   localparam int SUBSAMPLE_STEP = 3;

   // Multiply by reciprocal to test divisibility by the subsample step
   localparam int SUB_SHIFT   = COORD_BITS + 5;
   localparam int SUB_RECIP   = ((1 << SUB_SHIFT) + SUBSAMPLE_STEP - 1) / SUBSAMPLE_STEP;
   localparam int SUB_RECIP_W = SUB_SHIFT + 1;
   localparam int SUB_PROD_W  = COORD_BITS + SUB_RECIP_W;
   localparam int SUB_BACK_W  = COORD_BITS + 5;

   // Field widths
   localparam int MASK_W      = 8;
   localparam int DEPTH_W     = 16;
   localparam int COLOR_W     = 8;
   localparam int INV_FOCAL_W = 24;
   localparam int CENTER_W    = 16;
   localparam int POSE_W      = 64;
   localparam int ROT_W       = 14;
   localparam int TRANS_W     = 22;
   localparam int OUT_W       = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Depth window, Q4.12 meters
   localparam logic [DEPTH_W-1:0] DEPTH_MIN = 16'd41;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'd40960;

   // Datapath widths
   localparam int DX_W    = ((COORD_BITS + 4 > CENTER_W) ? COORD_BITS + 4 : CENTER_W) + 1;
   localparam int P1_W    = DX_W + DEPTH_W + 1;
   localparam int HALF_W  = INV_FOCAL_W / 2;
   localparam int PART_W  = P1_W + HALF_W + 1;
   localparam int FULL_W  = P1_W + INV_FOCAL_W + 1;
   localparam int CAM_W   = FULL_W - INV_FOCAL_W;
   localparam int CZ_W    = DEPTH_W + 5;
   localparam int PROD_W  = ROT_W + CAM_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int ACC_SHIFT = 16;

   typedef logic [SUB_PROD_W-1:0]     sub_prod_type;
   typedef logic [SUB_BACK_W-1:0]     sub_back_type;
   typedef logic signed [DX_W-1:0]    dx_type;
   typedef logic signed [P1_W-1:0]    p1_type;
   typedef logic signed [PART_W-1:0]  part_type;
   typedef logic signed [FULL_W-1:0]  full_type;
   typedef logic signed [CAM_W-1:0]   cam_type;
   typedef logic signed [CZ_W-1:0]    cz_type;
   typedef logic signed [ROT_W-1:0]   rot_type;
   typedef logic signed [TRANS_W-1:0] trans_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [OUT_W-1:0]   out_type;

   typedef struct packed {
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } color_type;

   localparam full_type CAM_ROUND = full_type'(1) <<< (INV_FOCAL_W - 1);
   localparam acc_type  OUT_ROUND = acc_type'(1) <<< (ACC_SHIFT - 1);
   localparam acc_type  SAT_HI    = acc_type'(8388607);
   localparam acc_type  SAT_LO    = acc_type'(-8388608);
   localparam out_type  OUT_MAX   = out_type'(8388607);
   localparam out_type  OUT_MIN   = out_type'(-8388608);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_FOCAL_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_FOCAL_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_COL  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_ROW  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSE_ROW_X  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSE_ROW_Y  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSE_ROW_Z  = 3'd6;

   // Reset values: identity pose, default intrinsics
   localparam logic [INV_FOCAL_W-1:0] INV_FOCAL_RESET  = 24'd31957;
   localparam logic [CENTER_W-1:0]    CENTER_COL_RESET = 16'd5112;
   localparam logic [CENTER_W-1:0]    CENTER_ROW_RESET = 16'd3832;
   localparam logic [POSE_W-1:0]      POSE_X_RESET     = 64'd4096;
   localparam logic [POSE_W-1:0]      POSE_Y_RESET     = 64'd67108864;
   localparam logic [POSE_W-1:0]      POSE_Z_RESET     = 64'd1099511627776;

   // k-th rotation factor of a packed pose row
   function automatic rot_type rot_field(input logic [POSE_W-1:0] row, input logic [1:0] k);
      rot_field = rot_type'(row[k*ROT_W +: ROT_W]);
   endfunction

   function automatic trans_type trans_field(input logic [POSE_W-1:0] row);
      trans_field = trans_type'(row[POSE_W-1 -: TRANS_W]);
   endfunction

endpackage

FILE: design/depth_pixel_to_world_point_core.sv
// Depth pixel to world point: subsample/mask/depth filter, pinhole
// back-projection and rigid transform, 8-stage pipeline. Uses dpw_pkg.
`timescale 1ns / 1ps

//  channel | ports                       | direction | handshake
//  req     | pixel, mask, depth, color   | in        | req_valid / req_stall
//  rsp     | world x/y/z, color          | out       | rsp_valid / rsp_stall
//  csr     | csr_index, csr_wdata        | in        | csr_we, no wait
//
//  One pixel per clock while req_stall is low; rsp_valid follows stage G.
//  Filtered pixels leave a bubble at stage B and give no result.
//  Each stage moves when the next one is empty or moving, so bubbles close
//  up; req_stall rises only with all stages full and rsp stalled.
//  Reset clears valid bits and loads the default intrinsics and identity pose.

module depth_pixel_to_world_point_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dpw_pkg::COORD_BITS-1:0]      req_pixel_row,
   input  logic [dpw_pkg::COORD_BITS-1:0]      req_pixel_col,
   input  logic [dpw_pkg::MASK_W-1:0]          req_mask_value,
   input  logic [dpw_pkg::DEPTH_W-1:0]         req_depth_value,
   input  logic [dpw_pkg::COLOR_W-1:0]         req_blue,
   input  logic [dpw_pkg::COLOR_W-1:0]         req_green,
   input  logic [dpw_pkg::COLOR_W-1:0]         req_red,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [dpw_pkg::OUT_W-1:0]    rsp_world_x,
   output logic signed [dpw_pkg::OUT_W-1:0]    rsp_world_y,
   output logic signed [dpw_pkg::OUT_W-1:0]    rsp_world_z,
   output logic [dpw_pkg::COLOR_W-1:0]         rsp_point_blue,
   output logic [dpw_pkg::COLOR_W-1:0]         rsp_point_green,
   output logic [dpw_pkg::COLOR_W-1:0]         rsp_point_red,
   input  logic                                csr_we,
   input  logic [dpw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dpw_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers (index 0 = x/col, 1 = y/row)
   logic [dpw_pkg::INV_FOCAL_W-1:0] inv_focal_ff [2];
   logic [dpw_pkg::CENTER_W-1:0]    center_ff    [2];
   logic [dpw_pkg::POSE_W-1:0]      pose_ff      [3];

   // Stage enables
   logic en_a, en_b, en_c, en_d, en_e, en_f, en_g, en_o;

   // Stage A: raw input
   logic                            valid_a_ff;
   logic [dpw_pkg::COORD_BITS-1:0]  coord_a_ff [2];
   logic [dpw_pkg::MASK_W-1:0]      mask_a_ff;
   logic [dpw_pkg::DEPTH_W-1:0]     depth_a_ff;
   dpw_pkg::color_type              color_a_ff, color_a_in;

   // Stage B: offsets from principal point
   logic                            valid_b_ff, valid_b_in;
   dpw_pkg::dx_type                 dx_b_ff [2], dx_b_in [2];
   logic [dpw_pkg::DEPTH_W-1:0]     depth_b_ff;
   dpw_pkg::color_type              color_b_ff;
   logic [1:0]                      on_grid;

   // Stage C: offset times depth
   logic                            valid_c_ff;
   dpw_pkg::p1_type                 p1_c_ff [2], p1_c_in [2];
   logic [dpw_pkg::DEPTH_W-1:0]     depth_c_ff;
   dpw_pkg::color_type              color_c_ff;

   // Stage D: partial products with the reciprocal focal length halves
   logic                            valid_d_ff;
   dpw_pkg::part_type               lo_d_ff [2], lo_d_in [2];
   dpw_pkg::part_type               hi_d_ff [2], hi_d_in [2];
   logic [dpw_pkg::DEPTH_W-1:0]     depth_d_ff;
   dpw_pkg::color_type              color_d_ff;

   // Stage E: camera coordinates, 16 fraction bits
   logic                            valid_e_ff;
   dpw_pkg::cam_type                cam_e_ff [2], cam_e_in [2];
   logic [dpw_pkg::DEPTH_W-1:0]     depth_e_ff;
   dpw_pkg::color_type              color_e_ff;

   // Stage F: rotation products
   logic                            valid_f_ff;
   dpw_pkg::prod_type               prod_f_ff [3][3], prod_f_in [3][3];
   dpw_pkg::color_type              color_f_ff;

   // Stage G: row sums with translation
   logic                            valid_g_ff;
   dpw_pkg::acc_type                acc_g_ff [3], acc_g_in [3];
   dpw_pkg::color_type              color_g_ff;

   // Output register
   logic                            rsp_valid_ff;
   dpw_pkg::out_type                world_ff [3], world_in [3];
   dpw_pkg::color_type              color_o_ff;

   // Ready chain from the output back to the input
   assign en_o = !rsp_valid_ff || !rsp_stall;
   assign en_g = !valid_g_ff || en_o;
   assign en_f = !valid_f_ff || en_g;
   assign en_e = !valid_e_ff || en_f;
   assign en_d = !valid_d_ff || en_e;
   assign en_c = !valid_c_ff || en_d;
   assign en_b = !valid_b_ff || en_c;
   assign en_a = !valid_a_ff || en_b;

   assign req_stall = !en_a;

   // Configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_focal_ff[0] <= dpw_pkg::INV_FOCAL_RESET;
         inv_focal_ff[1] <= dpw_pkg::INV_FOCAL_RESET;
         center_ff[0]    <= dpw_pkg::CENTER_COL_RESET;
         center_ff[1]    <= dpw_pkg::CENTER_ROW_RESET;
         pose_ff[0]      <= dpw_pkg::POSE_X_RESET;
         pose_ff[1]      <= dpw_pkg::POSE_Y_RESET;
         pose_ff[2]      <= dpw_pkg::POSE_Z_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dpw_pkg::CSR_INV_FOCAL_X: inv_focal_ff[0] <= csr_wdata[dpw_pkg::INV_FOCAL_W-1:0];
            dpw_pkg::CSR_INV_FOCAL_Y: inv_focal_ff[1] <= csr_wdata[dpw_pkg::INV_FOCAL_W-1:0];
            dpw_pkg::CSR_CENTER_COL:  center_ff[0]    <= csr_wdata[dpw_pkg::CENTER_W-1:0];
            dpw_pkg::CSR_CENTER_ROW:  center_ff[1]    <= csr_wdata[dpw_pkg::CENTER_W-1:0];
            dpw_pkg::CSR_POSE_ROW_X:  pose_ff[0]      <= csr_wdata;
            dpw_pkg::CSR_POSE_ROW_Y:  pose_ff[1]      <= csr_wdata;
            dpw_pkg::CSR_POSE_ROW_Z:  pose_ff[2]      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign color_a_in = '{blue: req_blue, green: req_green, red: req_red};

   // Stage B next: grid test, mask, depth window, offsets
   always_comb begin
      dpw_pkg::sub_prod_type prod;
      dpw_pkg::sub_back_type back;
      logic [dpw_pkg::COORD_BITS-1:0] quot;
      for (int k = 0; k < 2; k++) begin
         // quotient by reciprocal; exact over the whole coordinate range
         prod = dpw_pkg::sub_prod_type'(coord_a_ff[k])
              * dpw_pkg::sub_prod_type'(dpw_pkg::SUB_RECIP);
         quot = prod[dpw_pkg::SUB_SHIFT +: dpw_pkg::COORD_BITS];
         back = dpw_pkg::sub_back_type'(quot)
              * dpw_pkg::sub_back_type'(dpw_pkg::SUBSAMPLE_STEP);
         on_grid[k] = (back == dpw_pkg::sub_back_type'(coord_a_ff[k]));
         dx_b_in[k] = dpw_pkg::dx_type'(signed'({1'b0, coord_a_ff[k], 4'b0000}))
                    - dpw_pkg::dx_type'(signed'({1'b0, center_ff[k]}));
      end
      valid_b_in = valid_a_ff && (&on_grid) && (mask_a_ff == '0)
                && (depth_a_ff >= dpw_pkg::DEPTH_MIN) && (depth_a_ff <= dpw_pkg::DEPTH_MAX);
   end

   // Stages C, D, E next: back-projection
   always_comb begin
      dpw_pkg::full_type full;
      for (int k = 0; k < 2; k++) begin
         p1_c_in[k] = dpw_pkg::p1_type'(dx_b_ff[k])
                    * dpw_pkg::p1_type'(signed'({1'b0, depth_b_ff}));
         lo_d_in[k] = dpw_pkg::part_type'(p1_c_ff[k])
                    * dpw_pkg::part_type'(signed'({1'b0,
                         inv_focal_ff[k][dpw_pkg::HALF_W-1:0]}));
         hi_d_in[k] = dpw_pkg::part_type'(p1_c_ff[k])
                    * dpw_pkg::part_type'(signed'({1'b0,
                         inv_focal_ff[k][dpw_pkg::INV_FOCAL_W-1:dpw_pkg::HALF_W]}));
         // round half up, floor shift by 24
         full = (dpw_pkg::full_type'(hi_d_ff[k]) <<< dpw_pkg::HALF_W)
              + dpw_pkg::full_type'(lo_d_ff[k]) + dpw_pkg::CAM_ROUND;
         cam_e_in[k] = dpw_pkg::cam_type'(full >>> dpw_pkg::INV_FOCAL_W);
      end
   end

   // Stages F, G and output next: transform, round, saturate
   always_comb begin
      dpw_pkg::cz_type  cz;
      dpw_pkg::acc_type rnd;
      dpw_pkg::acc_type shv;
      cz = dpw_pkg::cz_type'(signed'({1'b0, depth_e_ff, 4'b0000}));
      for (int r = 0; r < 3; r++) begin
         prod_f_in[r][0] = dpw_pkg::prod_type'(dpw_pkg::rot_field(pose_ff[r], 2'd0))
                         * dpw_pkg::prod_type'(cam_e_ff[0]);
         prod_f_in[r][1] = dpw_pkg::prod_type'(dpw_pkg::rot_field(pose_ff[r], 2'd1))
                         * dpw_pkg::prod_type'(cam_e_ff[1]);
         prod_f_in[r][2] = dpw_pkg::prod_type'(dpw_pkg::rot_field(pose_ff[r], 2'd2))
                         * dpw_pkg::prod_type'(cz);
         acc_g_in[r] = dpw_pkg::acc_type'(prod_f_ff[r][0])
                     + dpw_pkg::acc_type'(prod_f_ff[r][1])
                     + dpw_pkg::acc_type'(prod_f_ff[r][2])
                     + (dpw_pkg::acc_type'(dpw_pkg::trans_field(pose_ff[r]))
                        <<< dpw_pkg::ACC_SHIFT);
         rnd = acc_g_ff[r] + dpw_pkg::OUT_ROUND;
         shv = rnd >>> dpw_pkg::ACC_SHIFT;
         if (shv > dpw_pkg::SAT_HI) begin
            world_in[r] = dpw_pkg::OUT_MAX;
         end else if (shv < dpw_pkg::SAT_LO) begin
            world_in[r] = dpw_pkg::OUT_MIN;
         end else begin
            world_in[r] = dpw_pkg::out_type'(shv[dpw_pkg::OUT_W-1:0]);
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         valid_c_ff   <= 1'b0;
         valid_d_ff   <= 1'b0;
         valid_e_ff   <= 1'b0;
         valid_f_ff   <= 1'b0;
         valid_g_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_a) valid_a_ff   <= req_valid;
         if (en_b) valid_b_ff   <= valid_b_in;
         if (en_c) valid_c_ff   <= valid_b_ff;
         if (en_d) valid_d_ff   <= valid_c_ff;
         if (en_e) valid_e_ff   <= valid_d_ff;
         if (en_f) valid_f_ff   <= valid_e_ff;
         if (en_g) valid_g_ff   <= valid_f_ff;
         if (en_o) rsp_valid_ff <= valid_g_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en_a) begin
         coord_a_ff[0] <= req_pixel_col;
         coord_a_ff[1] <= req_pixel_row;
         mask_a_ff     <= req_mask_value;
         depth_a_ff    <= req_depth_value;
         color_a_ff    <= color_a_in;
      end
      if (en_b) begin
         dx_b_ff    <= dx_b_in;
         depth_b_ff <= depth_a_ff;
         color_b_ff <= color_a_ff;
      end
      if (en_c) begin
         p1_c_ff    <= p1_c_in;
         depth_c_ff <= depth_b_ff;
         color_c_ff <= color_b_ff;
      end
      if (en_d) begin
         lo_d_ff    <= lo_d_in;
         hi_d_ff    <= hi_d_in;
         depth_d_ff <= depth_c_ff;
         color_d_ff <= color_c_ff;
      end
      if (en_e) begin
         cam_e_ff   <= cam_e_in;
         depth_e_ff <= depth_d_ff;
         color_e_ff <= color_d_ff;
      end
      if (en_f) begin
         prod_f_ff  <= prod_f_in;
         color_f_ff <= color_e_ff;
      end
      if (en_g) begin
         acc_g_ff   <= acc_g_in;
         color_g_ff <= color_f_ff;
      end
      if (en_o) begin
         world_ff   <= world_in;
         color_o_ff <= color_g_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_world_x     = world_ff[0];
   assign rsp_world_y     = world_ff[1];
   assign rsp_world_z     = world_ff[2];
   assign rsp_point_blue  = color_o_ff.blue;
   assign rsp_point_green = color_o_ff.green;
   assign rsp_point_red   = color_o_ff.red;

   // Input back-pressure only when every stage holds an item
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_a_ff && valid_b_ff && valid_c_ff && valid_d_ff && valid_e_ff
                    && valid_f_ff && valid_g_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled with a bubble in the pipeline");

   // An item waiting behind a stalled output is kept
   a_hold_g: assert property (@(posedge clock) disable iff (reset)
      valid_g_ff && rsp_valid_ff && rsp_stall |=> valid_g_ff)
      else $error("item lost in last stage during output stall");

   // Only pixels inside the depth window get past the filter
   a_depth_window: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff |-> (depth_b_ff >= dpw_pkg::DEPTH_MIN) && (depth_b_ff <= dpw_pkg::DEPTH_MAX))
      else $error("out-of-window depth passed the filter");

   // Pose row z write lands in its register
   a_pose_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == dpw_pkg::CSR_POSE_ROW_Z) |=> pose_ff[2] == $past(csr_wdata))
      else $error("pose row z write not taken");

endmodule
